// ----- rtl/core/cfpd_pkg.sv -----
`default_nettype none

package cfpd_pkg;

  // field widths
  localparam int FRAC_BITS = 16;
  localparam int GAIN_FRAC = 8;
  localparam int ID_W      = 11;
  localparam int BYTE_W    = 8;
  localparam int ADC_W     = 12;
  localparam int CODE_W    = 12;
  localparam int STAT_W    = 2;
  localparam int GAIN_W    = 16;
  localparam int SHAFT_W   = 14;
  localparam int WHEEL_W   = 12;
  localparam int GEAR_W    = 4;

  // datapath widths, all but Y_W follow from the fraction width
  localparam int RATIO_W = FRAC_BITS + 4;
  localparam int Q_W     = FRAC_BITS + 16;
  localparam int MA_W    = FRAC_BITS + 17;
  localparam int MB_W    = ((FRAC_BITS > 20) ? FRAC_BITS : 20) + 1;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = FRAC_BITS + 27;
  localparam int UB_W    = FRAC_BITS + 9;
  localparam int Y_W     = 19;

  // frame identifiers
  localparam logic [ID_W-1:0] ID_SHAFT = 11'h0AA;
  localparam logic [ID_W-1:0] ID_WHEEL = 11'h0CE;
  localparam logic [ID_W-1:0] ID_GEAR  = 11'h1D2;

  // gear range with a ratio entry
  localparam logic [GEAR_W-1:0] GEAR_MIN = 4'd5;
  localparam logic [GEAR_W-1:0] GEAR_MAX = 4'd11;

  // config register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'b1;
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd2560;

  // drive status codes
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd0;
  localparam logic [STAT_W-1:0] ST_LOW   = 2'd1;
  localparam logic [STAT_W-1:0] ST_HIGH  = 2'd2;
  localparam logic [STAT_W-1:0] ST_PASS  = 2'd3;

  localparam logic [CODE_W-1:0] CODE_LOW  = 12'd547;
  localparam logic [CODE_W-1:0] CODE_HIGH = 12'd2799;

  // fixed point constants, rounded to nearest at the fraction scale
  localparam logic [63:0] C_ADC_64   = ((64'd1776 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] C_OFF_64   = ((64'd972 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] C_OMEGA_64 =
    ((64'd6283184 << FRAC_BITS) + 64'd30000000) / 64'd60000000;
  localparam logic [63:0] C_WHEEL_64 = ((64'd100000 << FRAC_BITS) + 64'd57096) / 64'd114192;
  localparam logic [63:0] LIMIT_64   = 64'd400 << FRAC_BITS;

  localparam logic signed [ACC_W-1:0] OFF_ACC   = ACC_W'(C_OFF_64);
  localparam logic signed [ACC_W-1:0] LIMIT_ACC = ACC_W'(LIMIT_64);

  localparam logic signed [MB_W-1:0] C_ADC_MB   = MB_W'(C_ADC_64);
  localparam logic signed [MB_W-1:0] C_OMEGA_MB = MB_W'(C_OMEGA_64);
  localparam logic signed [MB_W-1:0] C_WHEEL_MB = MB_W'(C_WHEEL_64);

  // code = floor(floor((u + off) * 1000 / 2^F) / 178); the divide by 178 is a
  // multiply by ceil(2^27 / 178), exact for the bounded range of y
  localparam logic signed [MB_W-1:0] SCALE_MB    = MB_W'(1000);
  localparam logic signed [MB_W-1:0] RECIP_MB    = MB_W'(754033);
  localparam int                     RECIP_SHIFT = 27;

  // 3.15 times the gear constant, scaled by 1e6
  localparam logic [RATIO_W-1:0] RATIO_G5  =
    RATIO_W'(((64'd15056370 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [RATIO_W-1:0] RATIO_G6  =
    RATIO_W'(((64'd9627030 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [RATIO_W-1:0] RATIO_G7  =
    RATIO_W'(((64'd6781320 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [RATIO_W-1:0] RATIO_G8  =
    RATIO_W'(((64'd5286330 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [RATIO_W-1:0] RATIO_G9  =
    RATIO_W'(((64'd4378815 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [RATIO_W-1:0] RATIO_G10 =
    RATIO_W'(((64'd3789765 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [RATIO_W-1:0] RATIO_G11 =
    RATIO_W'(((64'd3150000 << FRAC_BITS) + 64'd500000) / 64'd1000000);

  function automatic logic [RATIO_W-1:0] ratio_lut(input logic [GEAR_W-1:0] gear);
    logic [RATIO_W-1:0] r;
    case (gear)
      4'd5:    r = RATIO_G5;
      4'd6:    r = RATIO_G6;
      4'd7:    r = RATIO_G7;
      4'd8:    r = RATIO_G8;
      4'd9:    r = RATIO_G9;
      4'd10:   r = RATIO_G10;
      default: r = RATIO_G11;
    endcase
    return r;
  endfunction

  // micro-op encodings
  typedef enum logic [3:0] {
    OP_NOP,
    OP_A_LOAD,
    OP_S_LOAD,
    OP_Q_LOAD,
    OP_D_SUBR,
    OP_U_SUB,
    OP_UB_LOAD,
    OP_Y_LOAD,
    OP_EMIT_CODE,
    OP_EMIT_LOW,
    OP_EMIT_HIGH,
    OP_EMIT_PASS,
    OP_FRAME
  } alu_op_t;

  typedef enum logic [2:0] {
    MA_ADC,
    MA_SHAFT,
    MA_RATIO,
    MA_Q,
    MA_D,
    MA_UB,
    MA_Y
  } mula_sel_t;

  typedef enum logic [2:0] {
    MB_CADC,
    MB_COMEGA,
    MB_WHEEL,
    MB_CWHEEL,
    MB_GAIN,
    MB_SCALE,
    MB_RECIP
  } mulb_sel_t;

  typedef enum logic [2:0] {
    J_NONE,
    J_FRAME,
    J_PASS,
    J_ULOW,
    J_UHIGH
  } jcond_t;

  localparam int PROG_LEN = 20;
  localparam int PC_W     = 5;

  localparam logic [PC_W-1:0] PC_LOW   = 5'd16;
  localparam logic [PC_W-1:0] PC_HIGH  = 5'd17;
  localparam logic [PC_W-1:0] PC_PASS  = 5'd18;
  localparam logic [PC_W-1:0] PC_FRAME = 5'd19;

  typedef struct packed {
    alu_op_t         alu;
    mula_sel_t       ma;
    mulb_sel_t       mb;
    logic            mul_en;
    jcond_t          jc;
    logic [PC_W-1:0] target;
    logic            last;
  } ucw_t;

  typedef struct packed {
    logic u_low;
    logic u_high;
  } dp_flags_t;

  // control store
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{alu: OP_NOP, ma: MA_ADC, mb: MB_CADC, mul_en: 1'b0, jc: J_NONE,
          target: '0, last: 1'b0};
    case (pc)
      // dispatch on item kind and enable
      5'd0: begin
        w.jc = J_FRAME;
        w.target = PC_FRAME;
      end
      5'd1: begin
        w.jc = J_PASS;
        w.target = PC_PASS;
      end
      // a = adc * A - B
      5'd2: begin
        w.mul_en = 1'b1;
        w.ma = MA_ADC;
        w.mb = MB_CADC;
      end
      5'd3: begin
        w.alu = OP_A_LOAD;
        w.mul_en = 1'b1;
        w.ma = MA_SHAFT;
        w.mb = MB_COMEGA;
      end
      // s, then ratio * wheel
      5'd4: begin
        w.alu = OP_S_LOAD;
        w.mul_en = 1'b1;
        w.ma = MA_RATIO;
        w.mb = MB_WHEEL;
      end
      5'd5: w.alu = OP_Q_LOAD;
      5'd6: begin
        w.mul_en = 1'b1;
        w.ma = MA_Q;
        w.mb = MB_CWHEEL;
      end
      // d = s - r
      5'd7: w.alu = OP_D_SUBR;
      5'd8: begin
        w.mul_en = 1'b1;
        w.ma = MA_D;
        w.mb = MB_GAIN;
      end
      // u = a - floor(gain * d / 2^8)
      5'd9: w.alu = OP_U_SUB;
      5'd10: begin
        w.jc = J_ULOW;
        w.target = PC_LOW;
      end
      5'd11: begin
        w.alu = OP_UB_LOAD;
        w.jc = J_UHIGH;
        w.target = PC_HIGH;
      end
      // code conversion
      5'd12: begin
        w.mul_en = 1'b1;
        w.ma = MA_UB;
        w.mb = MB_SCALE;
      end
      5'd13: w.alu = OP_Y_LOAD;
      5'd14: begin
        w.mul_en = 1'b1;
        w.ma = MA_Y;
        w.mb = MB_RECIP;
      end
      5'd15: begin
        w.alu = OP_EMIT_CODE;
        w.last = 1'b1;
      end
      5'd16: begin
        w.alu = OP_EMIT_LOW;
        w.last = 1'b1;
      end
      5'd17: begin
        w.alu = OP_EMIT_HIGH;
        w.last = 1'b1;
      end
      5'd18: begin
        w.alu = OP_EMIT_PASS;
        w.last = 1'b1;
      end
      5'd19: begin
        w.alu = OP_FRAME;
        w.last = 1'b1;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cfpd_datapath.sv -----
`default_nettype none

module cfpd_datapath (
  input  wire logic                          clk,
  input  wire logic                          go,
  input  wire cfpd_pkg::ucw_t                ctl,
  input  wire logic [cfpd_pkg::ADC_W-1:0]    adc,
  input  wire logic [cfpd_pkg::SHAFT_W-1:0]  shaft,
  input  wire logic [cfpd_pkg::WHEEL_W-1:0]  wheel,
  input  wire logic [cfpd_pkg::RATIO_W-1:0]  ratio,
  input  wire logic [cfpd_pkg::GAIN_W-1:0]   gain,
  output cfpd_pkg::dp_flags_t                flags,
  output logic [cfpd_pkg::CODE_W-1:0]        code
);

  logic signed [cfpd_pkg::MA_W-1:0]   mul_a;
  logic signed [cfpd_pkg::MB_W-1:0]   mul_b;
  logic signed [cfpd_pkg::PROD_W-1:0] prod_full;

  logic signed [cfpd_pkg::PROD_W-1:0] prod_r;
  logic signed [cfpd_pkg::ACC_W-1:0]  acc_r;
  logic signed [cfpd_pkg::MA_W-1:0]   d_r;
  logic [cfpd_pkg::Q_W-1:0]           q_r;
  logic [cfpd_pkg::UB_W-1:0]          ub_r;
  logic [cfpd_pkg::Y_W-1:0]           y_r;

  // multiplier operand select
  always_comb begin
    case (ctl.ma)
      cfpd_pkg::MA_ADC:   mul_a = cfpd_pkg::MA_W'(adc);
      cfpd_pkg::MA_SHAFT: mul_a = cfpd_pkg::MA_W'(shaft);
      cfpd_pkg::MA_RATIO: mul_a = cfpd_pkg::MA_W'(ratio);
      cfpd_pkg::MA_Q:     mul_a = cfpd_pkg::MA_W'(q_r);
      cfpd_pkg::MA_D:     mul_a = d_r;
      cfpd_pkg::MA_UB:    mul_a = cfpd_pkg::MA_W'(ub_r);
      cfpd_pkg::MA_Y:     mul_a = cfpd_pkg::MA_W'(y_r);
      default:            mul_a = '0;
    endcase
    case (ctl.mb)
      cfpd_pkg::MB_CADC:   mul_b = cfpd_pkg::C_ADC_MB;
      cfpd_pkg::MB_COMEGA: mul_b = cfpd_pkg::C_OMEGA_MB;
      cfpd_pkg::MB_WHEEL:  mul_b = cfpd_pkg::MB_W'(wheel);
      cfpd_pkg::MB_CWHEEL: mul_b = cfpd_pkg::C_WHEEL_MB;
      cfpd_pkg::MB_GAIN:   mul_b = cfpd_pkg::MB_W'(gain);
      cfpd_pkg::MB_SCALE:  mul_b = cfpd_pkg::SCALE_MB;
      cfpd_pkg::MB_RECIP:  mul_b = cfpd_pkg::RECIP_MB;
      default:             mul_b = '0;
    endcase
  end

  // shared signed multiplier, product registered
  assign prod_full = mul_a * mul_b;

  // working registers, one micro-op per step
  always_ff @(posedge clk) begin
    if (go) begin
      if (ctl.mul_en) begin
        prod_r <= prod_full;
      end
      case (ctl.alu)
        cfpd_pkg::OP_A_LOAD:  acc_r <= cfpd_pkg::ACC_W'(prod_r) - cfpd_pkg::OFF_ACC;
        cfpd_pkg::OP_S_LOAD:  d_r <= cfpd_pkg::MA_W'(prod_r);
        cfpd_pkg::OP_Q_LOAD:  q_r <= prod_r[cfpd_pkg::Q_W-1:0];
        cfpd_pkg::OP_D_SUBR:  d_r <= d_r - cfpd_pkg::MA_W'(prod_r >>> cfpd_pkg::FRAC_BITS);
        cfpd_pkg::OP_U_SUB:   acc_r <= acc_r - cfpd_pkg::ACC_W'(prod_r >>> cfpd_pkg::GAIN_FRAC);
        cfpd_pkg::OP_UB_LOAD: ub_r <= cfpd_pkg::UB_W'(acc_r + cfpd_pkg::OFF_ACC);
        cfpd_pkg::OP_Y_LOAD:  y_r <= prod_r[cfpd_pkg::FRAC_BITS +: cfpd_pkg::Y_W];
        default: ;
      endcase
    end
  end

  // sign and limit of u for the clamp jumps
  assign flags.u_low  = acc_r[cfpd_pkg::ACC_W-1];
  assign flags.u_high = (acc_r > cfpd_pkg::LIMIT_ACC);

  assign code = prod_r[cfpd_pkg::RECIP_SHIFT +: cfpd_pkg::CODE_W];

endmodule

`default_nettype wire

// ----- rtl/core/can_fed_proportional_drive_core.sv -----
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   kind, frame_id, bytes 1/4/5, adc_sample
// out_      output     out_valid / out_stall dac_code, drive_status
// cfg_      input      cfg_valid / cfg_ready index (0 enable, 1 gain), 16-bit data
//
// One item is worked at a time by a 20-step microprogram around one shared multiplier.
// A frame jumps to the frame step, a passthrough to the pass step, a clamped sample to
// the low or high step; an in-range sample is converted. At most one multiply per step.
// The next item is accepted in the cycle after the last step.
// Reset (synchronous) clears speeds and ratio, loads enable 0 and gain 10.0.
// A result waits in the output register; emitting holds while it is full and stalled.
module can_fed_proportional_drive_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input items
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_kind,
  input  wire logic [cfpd_pkg::ID_W-1:0]          in_frame_id,
  input  wire logic [cfpd_pkg::BYTE_W-1:0]        in_payload_byte1,
  input  wire logic [cfpd_pkg::BYTE_W-1:0]        in_payload_byte4,
  input  wire logic [cfpd_pkg::BYTE_W-1:0]        in_payload_byte5,
  input  wire logic [cfpd_pkg::ADC_W-1:0]         in_adc_sample,
  // results
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [cfpd_pkg::CODE_W-1:0]             out_dac_code,
  output logic [cfpd_pkg::STAT_W-1:0]             out_drive_status,
  // configuration
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cfpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cfpd_pkg::GAIN_W-1:0]        cfg_data
);

  // sequencer
  logic                        busy_r, busy_nxt;
  logic [cfpd_pkg::PC_W-1:0]   pc_r, pc_nxt;
  cfpd_pkg::ucw_t              ucw;
  cfpd_pkg::dp_flags_t         flags;
  logic                        in_beat;
  logic                        is_emit;
  logic                        out_free;
  logic                        go;
  logic                        take;

  // latched item
  logic                        kind_r;
  logic [cfpd_pkg::ID_W-1:0]   id_r;
  logic [cfpd_pkg::BYTE_W-1:0] b1_r, b4_r, b5_r;
  logic [cfpd_pkg::ADC_W-1:0]  adc_r;

  // config and stored state
  logic                          enable_r;
  logic [cfpd_pkg::GAIN_W-1:0]   gain_r;
  logic [cfpd_pkg::SHAFT_W-1:0]  shaft_r;
  logic [cfpd_pkg::WHEEL_W-1:0]  wheel_r;
  logic [cfpd_pkg::RATIO_W-1:0]  ratio_r;
  logic [2*cfpd_pkg::BYTE_W-1:0] word;
  logic [cfpd_pkg::GEAR_W-1:0]   gear;

  // output register
  logic                          out_valid_r;
  logic [cfpd_pkg::CODE_W-1:0]   out_code_r;
  logic [cfpd_pkg::STAT_W-1:0]   out_status_r;
  logic [cfpd_pkg::CODE_W-1:0]   dp_code;

  assign in_stall  = busy_r;
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign ucw = cfpd_pkg::ucode(pc_r);

  always_comb begin
    case (ucw.alu)
      cfpd_pkg::OP_EMIT_CODE,
      cfpd_pkg::OP_EMIT_LOW,
      cfpd_pkg::OP_EMIT_HIGH,
      cfpd_pkg::OP_EMIT_PASS: is_emit = 1'b1;
      default:                is_emit = 1'b0;
    endcase
  end

  // an emitting step waits for room in the output register
  assign out_free = !out_valid_r || !out_stall;
  assign go       = busy_r && (!is_emit || out_free);

  // jump conditions
  always_comb begin
    case (ucw.jc)
      cfpd_pkg::J_FRAME: take = !kind_r;
      cfpd_pkg::J_PASS:  take = !enable_r;
      cfpd_pkg::J_ULOW:  take = flags.u_low;
      cfpd_pkg::J_UHIGH: take = flags.u_high;
      default:           take = 1'b0;
    endcase
  end

  // step counter
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (in_beat) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (go) begin
      if (ucw.last) begin
        busy_nxt = 1'b0;
      end else if (take) begin
        pc_nxt = ucw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_beat) begin
      kind_r <= in_kind;
      id_r   <= in_frame_id;
      b1_r   <= in_payload_byte1;
      b4_r   <= in_payload_byte4;
      b5_r   <= in_payload_byte5;
      adc_r  <= in_adc_sample;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      gain_r   <= cfpd_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfpd_pkg::REG_ENABLE: enable_r <= cfg_data[0];
        cfpd_pkg::REG_GAIN:   gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame decode
  assign word = {b5_r, b4_r};
  assign gear = b1_r[cfpd_pkg::BYTE_W-1 -: cfpd_pkg::GEAR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shaft_r <= '0;
      wheel_r <= '0;
      ratio_r <= '0;
    end else if (go && (ucw.alu == cfpd_pkg::OP_FRAME)) begin
      if (id_r == cfpd_pkg::ID_SHAFT) begin
        shaft_r <= word[2 +: cfpd_pkg::SHAFT_W];
      end
      if (id_r == cfpd_pkg::ID_WHEEL) begin
        wheel_r <= word[4 +: cfpd_pkg::WHEEL_W];
      end
      if ((id_r == cfpd_pkg::ID_GEAR) && (gear >= cfpd_pkg::GEAR_MIN) &&
          (gear <= cfpd_pkg::GEAR_MAX)) begin
        ratio_r <= cfpd_pkg::ratio_lut(gear);
      end
    end
  end

  cfpd_datapath u_dp (
    .clk   (clk),
    .go    (go),
    .ctl   (ucw),
    .adc   (adc_r),
    .shaft (shaft_r),
    .wheel (wheel_r),
    .ratio (ratio_r),
    .gain  (gain_r),
    .flags (flags),
    .code  (dp_code)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && is_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && is_emit) begin
      case (ucw.alu)
        cfpd_pkg::OP_EMIT_LOW: begin
          out_code_r   <= cfpd_pkg::CODE_LOW;
          out_status_r <= cfpd_pkg::ST_LOW;
        end
        cfpd_pkg::OP_EMIT_HIGH: begin
          out_code_r   <= cfpd_pkg::CODE_HIGH;
          out_status_r <= cfpd_pkg::ST_HIGH;
        end
        cfpd_pkg::OP_EMIT_PASS: begin
          out_code_r   <= adc_r;
          out_status_r <= cfpd_pkg::ST_PASS;
        end
        default: begin
          out_code_r   <= dp_code;
          out_status_r <= cfpd_pkg::ST_RANGE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dac_code     = out_code_r;
  assign out_drive_status = out_status_r;

  // checks
  a_emit_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (go && is_emit) |=> !busy_r)
    else $error("emitting step did not end the item");

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r < cfpd_pkg::PC_W'(cfpd_pkg::PROG_LEN)))
    else $error("step counter left the control store");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (busy_r && (pc_r == '0)))
    else $error("accepted beat did not start the program");

  a_low_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_drive_status == cfpd_pkg::ST_LOW)) |->
      (out_dac_code == cfpd_pkg::CODE_LOW))
    else $error("clamped low result with wrong code");

endmodule

`default_nettype wire

// ----- tb/sv/can_fed_proportional_drive_core_test.sv -----
`default_nettype none

module can_fed_proportional_drive_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // fixed point constants, rounded to nearest at the fraction scale
  localparam int     FRAC     = cfpd_pkg::FRAC_BITS;
  localparam longint FX_UNIT  = longint'(1) << FRAC;
  localparam longint K_ADC    = ((longint'(1776) << FRAC) + 5000) / 10000;
  localparam longint K_OFF    = ((longint'(972) << FRAC) + 5) / 10;
  localparam longint K_OMEGA  = ((longint'(6283184) << FRAC) + 30000000) / 60000000;
  localparam longint K_WHEEL  = ((longint'(100000) << FRAC) + 57096) / 114192;
  localparam longint U_MAX    = longint'(400) << FRAC;
  localparam int     SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [cfpd_pkg::CODE_W-1:0] code;
    logic [cfpd_pkg::STAT_W-1:0] status;
  } dac_beat_t;

  // dut signals
  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_kind = 1'b0;
  logic [cfpd_pkg::ID_W-1:0]      in_frame_id = '0;
  logic [cfpd_pkg::BYTE_W-1:0]    in_payload_byte1 = '0;
  logic [cfpd_pkg::BYTE_W-1:0]    in_payload_byte4 = '0;
  logic [cfpd_pkg::BYTE_W-1:0]    in_payload_byte5 = '0;
  logic [cfpd_pkg::ADC_W-1:0]     in_adc_sample = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [cfpd_pkg::CODE_W-1:0]    out_dac_code;
  logic [cfpd_pkg::STAT_W-1:0]    out_drive_status;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [cfpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cfpd_pkg::GAIN_W-1:0]    cfg_data = '0;

  // predictor state and configuration
  logic                           drv_enable = 1'b0;
  logic [cfpd_pkg::GAIN_W-1:0]    drv_gain = cfpd_pkg::GAIN_RESET;
  logic [cfpd_pkg::SHAFT_W-1:0]   shaft_now = '0;
  logic [cfpd_pkg::WHEEL_W-1:0]   wheel_now = '0;
  longint                         ratio_now = 0;

  // dac beats still to come, oldest first
  dac_beat_t            dac_due[$];

  int tx_idle_pct = 25;
  int rx_idle_pct = 76;
  int err_count = 0;
  int mismatch_count = 0;

  // long receiver hold, requested by the test and counted by the stall process
  int hold_len = 0;
  int hold_req_id = 0;
  int hold_ack_id = 0;
  int hold_left = 0;

  can_fed_proportional_drive_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_frame_id      (in_frame_id),
    .in_payload_byte1 (in_payload_byte1),
    .in_payload_byte4 (in_payload_byte4),
    .in_payload_byte5 (in_payload_byte5),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dac_code     (out_dac_code),
    .out_drive_status (out_drive_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // expected dac beat for one adc sample under the current state
  function automatic dac_beat_t predict_dac(input logic [cfpd_pkg::ADC_W-1:0] adc);
    longint    a;
    longint    s;
    longint    r;
    longint    g;
    longint    u;
    dac_beat_t b;
    if (!drv_enable) begin
      b.code = adc;
      b.status = cfpd_pkg::ST_PASS;
      return b;
    end
    a = longint'(adc) * K_ADC - K_OFF;
    s = longint'(shaft_now) * K_OMEGA;
    r = (ratio_now * longint'(wheel_now) * K_WHEEL) >>> FRAC;
    // arithmetic shift floors toward minus infinity
    g = (longint'(drv_gain) * (s - r)) >>> cfpd_pkg::GAIN_FRAC;
    u = a - g;
    if (u < 0) begin
      b.code = cfpd_pkg::CODE_LOW;
      b.status = cfpd_pkg::ST_LOW;
    end else if (u > U_MAX) begin
      b.code = cfpd_pkg::CODE_HIGH;
      b.status = cfpd_pkg::ST_HIGH;
    end else begin
      b.code = cfpd_pkg::CODE_W'(((u + K_OFF) * 1000) / (178 * FX_UNIT));
      b.status = cfpd_pkg::ST_RANGE;
    end
    return b;
  endfunction

  // offer one item, wait for its beat, then update the predictor
  task automatic send_item(input logic kind, input logic [cfpd_pkg::ID_W-1:0] fid,
                           input logic [cfpd_pkg::BYTE_W-1:0] b1,
                           input logic [cfpd_pkg::BYTE_W-1:0] b4,
                           input logic [cfpd_pkg::BYTE_W-1:0] b5,
                           input logic [cfpd_pkg::ADC_W-1:0] adc);
    longint e6;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_frame_id <= fid;
    in_payload_byte1 <= b1;
    in_payload_byte4 <= b4;
    in_payload_byte5 <= b5;
    in_adc_sample <= adc;
    do @(posedge clk); while (in_stall);
    if (kind) begin
      dac_due.push_back(predict_dac(adc));
    end else begin
      case (fid)
        cfpd_pkg::ID_SHAFT: shaft_now = {b5, b4} >> 2;
        cfpd_pkg::ID_WHEEL: wheel_now = {b5, b4} >> 4;
        cfpd_pkg::ID_GEAR: begin
          // 3.15 times the gear constant, scaled by 1e6
          case (b1[7:4])
            4'd5:    e6 = 15056370;
            4'd6:    e6 = 9627030;
            4'd7:    e6 = 6781320;
            4'd8:    e6 = 5286330;
            4'd9:    e6 = 4378815;
            4'd10:   e6 = 3789765;
            4'd11:   e6 = 3150000;
            default: e6 = 0;
          endcase
          if (e6 != 0) ratio_now = ((e6 << FRAC) + 500000) / 1000000;
        end
        default: ;
      endcase
    end
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_frame(input logic [cfpd_pkg::ID_W-1:0] fid,
                            input logic [cfpd_pkg::BYTE_W-1:0] b1,
                            input logic [15:0] word);
    send_item(1'b0, fid, b1, word[7:0], word[15:8], cfpd_pkg::ADC_W'($urandom));
  endtask

  task automatic send_sample(input logic [cfpd_pkg::ADC_W-1:0] adc);
    send_item(1'b1, cfpd_pkg::ID_W'($urandom), cfpd_pkg::BYTE_W'($urandom),
              cfpd_pkg::BYTE_W'($urandom), cfpd_pkg::BYTE_W'($urandom), adc);
  endtask

  // stop offering, wait for every due beat, then let the sequencer finish
  task automatic settle();
    in_valid <= 1'b0;
    while (dac_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [cfpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cfpd_pkg::GAIN_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == cfpd_pkg::REG_ENABLE) drv_enable = data[0];
    else if (idx == cfpd_pkg::REG_GAIN) drv_gain = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // regulator off after reset, unknown frames dropped
  task automatic test_passthrough();
    send_sample(12'd0);
    send_frame(11'd0, 8'hFF, 16'hFFFF);
    send_frame(11'h7FF, 8'hFF, 16'hFFFF);
    send_sample(12'hFFF);
  endtask

  // regulator on with the reset gain and no gear seen yet
  task automatic test_unset_ratio();
    write_reg(cfpd_pkg::REG_ENABLE, 16'd1);
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'd1200);
    send_frame(cfpd_pkg::ID_SHAFT, 8'h00, 16'hFFFF);
    send_frame(cfpd_pkg::ID_WHEEL, 8'h00, 16'hFFFF);
    send_sample(12'd3000);
  endtask

  // each valid gear sets its ratio, gears outside the table keep the old one
  task automatic test_gear_select();
    send_frame(cfpd_pkg::ID_WHEEL, 8'h00, 16'h0400);
    for (int g = 5; g <= 11; g++) begin
      send_frame(cfpd_pkg::ID_GEAR, {4'(g), 4'($urandom)}, 16'($urandom));
      send_sample(12'd2000);
    end
    send_frame(cfpd_pkg::ID_GEAR, 8'h0F, 16'($urandom));
    send_frame(cfpd_pkg::ID_GEAR, 8'hF0, 16'($urandom));
    send_sample(12'd2000);
  endtask

  task automatic test_gain_extremes();
    write_reg(cfpd_pkg::REG_GAIN, 16'h0000);
    send_sample(12'd2000);
    write_reg(cfpd_pkg::REG_GAIN, 16'hFFFF);
    send_sample(12'd2000);
  endtask

  // mostly well-formed frame traffic with samples, plus unknown-id noise
  task automatic test_random_traffic(input int beats, input int tx_pct, input int rx_pct,
                                     input logic en,
                                     input logic [cfpd_pkg::GAIN_W-1:0] gain_val);
    int          n;
    int          pick;
    logic [15:0] word;
    logic [3:0]  gear;
    longint      shaft_goal;
    write_reg(cfpd_pkg::REG_ENABLE, {15'd0, en});
    write_reg(cfpd_pkg::REG_GAIN, gain_val);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    n = 0;
    while (n < beats) begin
      pick = $urandom_range(99);
      word = 16'($urandom);
      if (pick < 40) begin
        send_sample(cfpd_pkg::ADC_W'($urandom));
        n++;
      end else if (pick < 55) begin
        // half the shaft frames track the wheel so the slip stays small
        if ($urandom_range(1)) begin
          shaft_goal = ((ratio_now * longint'(wheel_now) * K_WHEEL) >>> FRAC) / K_OMEGA
                       + int'($urandom_range(16)) - 8;
          if (shaft_goal < 0) shaft_goal = 0;
          if (shaft_goal > 16383) shaft_goal = 16383;
          word = {shaft_goal[13:0], word[1:0]};
        end
        send_frame(cfpd_pkg::ID_SHAFT, cfpd_pkg::BYTE_W'($urandom), word);
        n++;
      end else if (pick < 67) begin
        if ($urandom_range(1)) word = 16'($urandom_range(16383));
        send_frame(cfpd_pkg::ID_WHEEL, cfpd_pkg::BYTE_W'($urandom), word);
        n++;
      end else if (pick < 82) begin
        gear = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(11, 5));
        send_frame(cfpd_pkg::ID_GEAR, {gear, 4'($urandom)}, word);
        n++;
      end else begin
        send_frame(cfpd_pkg::ID_W'($urandom), cfpd_pkg::BYTE_W'($urandom), word);
        n++;
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, then the sender pauses
  task automatic test_output_hold();
    write_reg(cfpd_pkg::REG_ENABLE, 16'd1);
    write_reg(cfpd_pkg::REG_GAIN, cfpd_pkg::GAIN_RESET);
    tx_idle_pct = 0;
    rx_idle_pct = 30;
    hold_len = 400;
    hold_req_id++;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 3) send_frame(cfpd_pkg::ID_SHAFT, 8'h00, 16'($urandom));
      else send_sample(cfpd_pkg::ADC_W'($urandom));
    end
    settle();
    for (int i = 0; i < 6; i++) send_sample(cfpd_pkg::ADC_W'($urandom));
  endtask

  // receiver stall, one assignment per falling edge
  always @(negedge clk) begin
    if (hold_ack_id != hold_req_id) begin
      hold_ack_id = hold_req_id;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // compare each accepted dac beat with the oldest one due
  always @(posedge clk) begin : check_beat
    dac_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (dac_due.size() == 0) begin
        err_count++;
        if (mismatch_count < 10)
          $display("unexpected dac beat: code %0d status %0d", out_dac_code,
                   out_drive_status);
        mismatch_count++;
      end else begin
        want = dac_due.pop_front();
        if (out_dac_code !== want.code || out_drive_status !== want.status) begin
          err_count++;
          if (mismatch_count < 10)
            $display("dac beat mismatch: code exp %0d got %0d, status exp %0d got %0d",
                     want.code, out_dac_code, want.status, out_drive_status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("can_fed_proportional_drive_core_test: done, errors");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_passthrough();
    test_unset_ratio();
    test_gear_select();
    test_gain_extremes();
    test_random_traffic(300, 25, 76, 1'b1, cfpd_pkg::GAIN_W'($urandom_range(1023)));
    test_random_traffic(300, 76, 25, 1'b1, 16'hFFFF);
    test_random_traffic(150, 0, 0, 1'b1, cfpd_pkg::GAIN_W'($urandom));
    test_random_traffic(150, 0, 0, 1'b0, cfpd_pkg::GAIN_RESET);
    test_output_hold();
    settle();
    if (err_count == 0) begin
      $display("can_fed_proportional_drive_core_test: done, clean");
    end else begin
      $display("can_fed_proportional_drive_core_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/cfpd_pkg.sv
rtl/core/cfpd_datapath.sv
rtl/core/can_fed_proportional_drive_core.sv
tb/sv/can_fed_proportional_drive_core_test.sv
